// File: hw/rtl/bbr_pkg.sv
// Package for the 3x3 box blur: widths, register indexes, divide-by-9 constants
// and the small structs passed between the blur modules.
// No dependencies.
package bbr_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
   localparam int CFG_W  = 11;
   localparam int POS_W  = CFG_W + 1;
   localparam int RGB_W  = 24;
   localparam int CH_W   = 8;
   localparam int SUM_W  = 12;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS  = 1'd1;

   localparam logic [CFG_W-1:0] LINE_LENGTH_RESET = 11'd800;
   localparam logic [CFG_W-1:0] FRAME_ROWS_RESET  = 11'd600;

   // truncating divide by 9 as (sum * 7282) >> 16, exact for sums up to 9 * 255
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int DIV9_SHIFT = 16;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

   localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // what the position tracker tells the pipeline about one item
   typedef struct packed {
      logic             has_result;
      logic             last;
      logic             left_ok;
      logic             right_ok;
      logic             top_ok;
      logic             bot_ok;
      logic [COL_W-1:0] addr;
   } pos_info_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sum_type;

endpackage

// File: hw/rtl/bbr_req_if.sv
// Input channel of the box blur: valid/ready handshake with one pixel item.
// Depends on nothing.
interface bbr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_word;
   logic        drain;

   modport source (output valid, output pixel_word, output drain, input ready);
   modport sink   (input valid, input pixel_word, input drain, output ready);
endinterface

// File: hw/rtl/bbr_rsp_if.sv
// Result channel of the box blur: valid/ready handshake with one blurred pixel.
// Depends on nothing.
interface bbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] blurred_pixel;
   logic        last_of_frame;

   modport source (output valid, output blurred_pixel, output last_of_frame, input ready);
   modport sink   (input valid, input blurred_pixel, input last_of_frame, output ready);
endinterface

// File: hw/rtl/bbr_position.sv
// Frame position tracker: column and row of the next item, window center,
// edge masks and end-of-frame flag. Depends on bbr_pkg.
module bbr_position
   import bbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [CFG_W-1:0]   line_length,
   input  logic [CFG_W-1:0]   frame_rows,
   output pos_info_type       info
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [POS_W-1:0] w, h;
   logic [POS_W-1:0] col_a, row_a, x, y, xc, yc, col_n, row_n;
   logic             ok, has_result, last;

   // clamp the registers to 1..max
   always_comb begin
      if (line_length == '0) begin
         w = POS_W'(1);
      end else if (POS_W'(line_length) > POS_W'(MAX_WIDTH)) begin
         w = POS_W'(MAX_WIDTH);
      end else begin
         w = POS_W'(line_length);
      end
      if (frame_rows == '0) begin
         h = POS_W'(1);
      end else if (POS_W'(frame_rows) > POS_W'(MAX_HEIGHT)) begin
         h = POS_W'(MAX_HEIGHT);
      end else begin
         h = POS_W'(frame_rows);
      end
   end

   // sanitize position, find window center, compute next position
   always_comb begin
      if (POS_W'(col_ff) >= w) begin
         col_a = '0;
         row_a = POS_W'(row_ff) + POS_W'(1);
      end else begin
         col_a = POS_W'(col_ff);
         row_a = POS_W'(row_ff);
      end
      if (row_a > h + POS_W'(1) || (row_a == h + POS_W'(1) && col_a != '0)) begin
         x = '0;
         y = '0;
      end else begin
         x = col_a;
         y = row_a;
      end

      if (x != '0) begin
         xc = x - POS_W'(1);
         ok = (y >= POS_W'(1));
         yc = y - POS_W'(1);
      end else begin
         xc = w - POS_W'(1);
         ok = (y >= POS_W'(2));
         yc = y - POS_W'(2);
      end
      has_result = ok && (yc < h);
      last       = has_result && (xc == w - POS_W'(1)) && (yc == h - POS_W'(1));

      col_n = x + POS_W'(1);
      row_n = y;
      if (last) begin
         col_n = '0;
         row_n = '0;
      end else if (col_n >= w) begin
         col_n = '0;
         row_n = y + POS_W'(1);
      end
      col_in = col_n[COL_W-1:0];
      row_in = row_n[ROW_W-1:0];

      info.has_result = has_result;
      info.last       = last;
      info.left_ok    = (xc != '0);
      info.right_ok   = (xc + POS_W'(1) < w);
      info.top_ok     = (yc != '0);
      info.bot_ok     = (yc + POS_W'(1) < h);
      info.addr       = x[COL_W-1:0];
   end

   // advance on every accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: hw/rtl/bbr_line_store.sv
// Two line memories holding the RGB of the previous two rows, registered
// read, with a bypass when a read hits the address written in the same cycle.
// Depends on bbr_pkg.
module bbr_line_store
   import bbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [COL_W-1:0]   rd_addr,
   input  logic               wr_en,
   input  logic [COL_W-1:0]   wr_addr,
   input  logic [RGB_W-1:0]   wr_upper,
   input  logic [RGB_W-1:0]   wr_lower,
   output logic [RGB_W-1:0]   rd_upper,
   output logic [RGB_W-1:0]   rd_lower
);

   logic [RGB_W-1:0] upper_mem_ff [MAX_WIDTH];
   logic [RGB_W-1:0] lower_mem_ff [MAX_WIDTH];

   logic [RGB_W-1:0] upper_q_ff, lower_q_ff;
   logic [RGB_W-1:0] upper_fwd_ff, lower_fwd_ff;
   logic             fwd_ff, fwd_in;

   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem_ff[wr_addr] <= wr_upper;
         lower_mem_ff[wr_addr] <= wr_lower;
      end
   end

   // read port: hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_q_ff <= upper_mem_ff[rd_addr];
         lower_q_ff <= lower_mem_ff[rd_addr];
      end
   end

   // capture write data on a same-address collision
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_in) begin
         upper_fwd_ff <= wr_upper;
         lower_fwd_ff <= wr_lower;
      end
   end

   assign rd_upper = fwd_ff ? upper_fwd_ff : upper_q_ff;
   assign rd_lower = fwd_ff ? lower_fwd_ff : lower_q_ff;

endmodule

// File: hw/rtl/bbr_out_stage.sv
// Output stage: divides the three channel sums by 9 and holds the packed
// result item until it is taken. Depends on bbr_pkg and bbr_rsp_if.
module bbr_out_stage
   import bbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  sum_type     in_sum,
   input  logic        in_last,
   bbr_rsp_if.source   rsp_ch
);

   logic              rsp_valid_ff;
   logic [31:0]       pixel_ff, pixel_in;
   logic              last_ff;
   logic              load;
   logic [PROD_W-1:0] prod_r, prod_g, prod_b;

   assign in_ready = !rsp_valid_ff || rsp_ch.ready;
   assign load     = in_valid && in_ready;

   // divide by 9 through the reciprocal
   always_comb begin
      prod_r   = PROD_W'(in_sum.red)   * PROD_W'(DIV9_RECIP);
      prod_g   = PROD_W'(in_sum.green) * PROD_W'(DIV9_RECIP);
      prod_b   = PROD_W'(in_sum.blue)  * PROD_W'(DIV9_RECIP);
      pixel_in = {prod_r[DIV9_SHIFT +: CH_W], prod_g[DIV9_SHIFT +: CH_W],
                  prod_b[DIV9_SHIFT +: CH_W], ALPHA_OPAQUE};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
         last_ff  <= in_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.blurred_pixel = pixel_ff;
   assign rsp_ch.last_of_frame = last_ff;

endmodule

// File: hw/rtl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur: configuration registers,
// window columns and channel sums. Depends on bbr_pkg, the two channel
// interfaces, bbr_position, bbr_line_store and bbr_out_stage.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------
//   req_ch   | in  | valid / ready     | pixel_word[31:0], drain
//   rsp_ch   | out | valid / ready     | blurred_pixel[31:0], last_of_frame
//   csr_*    | in  | csr_wr_en         | csr_index[0], csr_wdata[10:0]
//
// One item per cycle while no result stalls; a result passes the stage 1, stage 2
// and output registers after its source item is accepted. The rate is bounded by
// the single read and single write port of each line memory used once per item.
// Reset is synchronous and clears counters, window and valid flags; the line
// memories need no clearing pass, as never-written entries only feed masked taps.
// A stalled result holds the pipeline stage by stage; items without a result
// keep flowing and the input stays ready while a stage ahead has room.
module box_blur_3x3_rgb
   import bbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bbr_req_if.sink               req_ch,
   bbr_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [CFG_W-1:0] line_length_ff, frame_rows_ff;

   pos_info_type     pos_info;
   logic             accept;

   logic             s1_valid_ff;
   pos_info_type     s1_info_ff;
   logic [RGB_W-1:0] s1_px_ff, px_in;
   logic             adv1;

   logic [RGB_W-1:0] top_px, mid_px;
   logic [RGB_W-1:0] win_ff [6];

   logic             s2_valid_ff;
   sum_type          s2_sum_ff, sum_in;
   logic             s2_last_ff;
   logic             s2_free, out_ready;

   logic [RGB_W-1:0] taps [9];
   logic             use_tap [9];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         frame_rows_ff  <= FRAME_ROWS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_LENGTH: line_length_ff <= csr_wdata;
            CSR_FRAME_ROWS:  frame_rows_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake between stages
   assign s2_free       = !s2_valid_ff || out_ready;
   assign adv1          = s1_valid_ff && (!s1_info_ff.has_result || s2_free);
   assign req_ch.ready  = !s1_valid_ff || adv1;
   assign accept        = req_ch.valid && req_ch.ready;
   assign px_in         = req_ch.drain ? '0 : req_ch.pixel_word[31:8];

   bbr_position u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .line_length (line_length_ff),
      .frame_rows  (frame_rows_ff),
      .info        (pos_info)
   );

   bbr_line_store u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (pos_info.addr),
      .wr_en    (adv1),
      .wr_addr  (s1_info_ff.addr),
      .wr_upper (mid_px),
      .wr_lower (s1_px_ff),
      .rd_upper (top_px),
      .rd_lower (mid_px)
   );

   // stage 1: item waits for its line memory data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= pos_info;
         s1_px_ff   <= px_in;
      end
   end

   // shift the window by one column per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (adv1) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= s1_px_ff;
      end
   end

   // gather taps in row-major order and mask those outside the frame
   always_comb begin
      taps[0] = win_ff[0];
      taps[1] = win_ff[3];
      taps[2] = top_px;
      taps[3] = win_ff[1];
      taps[4] = win_ff[4];
      taps[5] = mid_px;
      taps[6] = win_ff[2];
      taps[7] = win_ff[5];
      taps[8] = s1_px_ff;
      for (int i = 0; i < 9; i++) begin
         use_tap[i] = ((i % 3) != 0 || s1_info_ff.left_ok) &&
                      ((i % 3) != 2 || s1_info_ff.right_ok) &&
                      ((i / 3) != 0 || s1_info_ff.top_ok) &&
                      ((i / 3) != 2 || s1_info_ff.bot_ok);
      end
      sum_in = '0;
      for (int i = 0; i < 9; i++) begin
         if (use_tap[i]) begin
            sum_in.red   = sum_in.red   + SUM_W'(taps[i][23:16]);
            sum_in.green = sum_in.green + SUM_W'(taps[i][15:8]);
            sum_in.blue  = sum_in.blue  + SUM_W'(taps[i][7:0]);
         end
      end
   end

   // stage 2: hold the sums of items that give a result
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= adv1 && s1_info_ff.has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && adv1 && s1_info_ff.has_result) begin
         s2_sum_ff  <= sum_in;
         s2_last_ff <= s1_info_ff.last;
      end
   end

   bbr_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_ready (out_ready),
      .in_sum   (s2_sum_ff),
      .in_last  (s2_last_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: hw/rtl/bbr_checker.sv
// Port-level checks of the box blur top level, attached by the bind below.
// Depends on bbr_pkg and box_blur_3x3_rgb.
module bbr_checker
   import bbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_ready,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pixel,
   input  logic        rsp_last
);

   // leave reset empty and ready for an item
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

   // every result carries an opaque alpha byte
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel[7:0] == ALPHA_OPAQUE))
      else $error("result alpha byte not opaque");

   // hold a stalled result item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pixel) && $stable(rsp_last)))
      else $error("stalled result item changed");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pixel (rsp_ch.blurred_pixel),
   .rsp_last  (rsp_ch.last_of_frame)
);
